@@ src/tracker_pattern_unpacker_assert.svh @@
// Assertion macros for the pattern unpacker checker.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef TRACKER_PATTERN_UNPACKER_ASSERT_SVH
`define TRACKER_PATTERN_UNPACKER_ASSERT_SVH

// Same-cycle implication.
`define TPU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TPU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tpu_pkg.sv @@
// Shared types and constants of the pattern unpacker.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package tpu_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ROWCFG_W   = 9;
  localparam int unsigned CHCFG_W    = 7;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned CH_W       = 7;
  localparam int unsigned REC_W      = 15;
  localparam int unsigned IDX_W      = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned NFIELDS    = 7;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned DIV_W      = 9;
  localparam int unsigned DIV_STEPS  = DIV_W;
  localparam int unsigned STEP_CNT_W = 4;
  localparam int unsigned CELL_W     = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PACKED_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic                RST_PACKED_MODE = 1'b1;
  localparam logic [ROWCFG_W-1:0] RST_ROW_COUNT   = 9'd64;
  localparam logic [CHCFG_W-1:0]  RST_CHAN_COUNT  = 7'd4;
  localparam logic [CHCFG_W-1:0]  MIN_CHANNELS    = 7'd4;

  // Packed-mode parse phases; in plain mode the phase is the byte position
  localparam logic [PHASE_W-1:0] PH_MASK     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_REPEAT   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_MASK_FF  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FIELDS   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_POS_LAST = 3'd6;

  // Field slots of a cell record
  localparam int unsigned F_NOTE   = 0;
  localparam int unsigned F_INSTR  = 1;
  localparam int unsigned F_VOL    = 2;
  localparam int unsigned F_EFFECT = 4;
  localparam int unsigned F_ARG1   = 5;
  localparam int unsigned F_ARG2   = 6;

  localparam logic [DATA_W-1:0] REPEAT_MARK = 8'hFF;
  localparam logic [DATA_W-1:0] MASK_BITS   = 8'h7F;
  localparam logic [DATA_W-1:0] NOTE_LAST   = 8'd96;
  localparam logic [DATA_W-1:0] NOTE_OFF    = 8'hFF;
  localparam logic [DATA_W-1:0] NOTE_SHIFT  = 8'd12;
  localparam logic [DATA_W-1:0] VOL_SET_LO  = 8'h10;
  localparam logic [DATA_W-1:0] VOL_SET_HI  = 8'h90;
  localparam logic [DATA_W-1:0] VOL_SLD_LO  = 8'hA0;
  localparam logic [DATA_W-1:0] VOL_SLD_HI  = 8'hDF;
  localparam logic [3:0]        VOL_SLD_NIB = 4'hA;

  // Volume column kinds
  localparam logic [2:0] VK_NONE     = 3'd0;
  localparam logic [2:0] VK_SET      = 3'd1;
  localparam logic [2:0] VK_SLIDE_DN = 3'd2;
  localparam logic [2:0] VK_FINE_UP  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WRAP
  } tpu_state_e;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic [7:0]  effect_arg_two;
    logic [7:0]  effect_arg_one;
    logic [7:0]  effect_code;
    logic [6:0]  volume_value;
    logic [2:0]  volume_kind;
    logic [7:0]  instrument;
    logic [7:0]  note_code;
    logic [13:0] cell_index;
  } cell_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_divide;
    logic queue_full;
  } dp_status_t;

endpackage

@@ src/tpu_ctrl.sv @@
// Sequencer of the pattern unpacker: gates input transactions and runs the row-wrap divider.
// Depends on tpu_pkg.
`timescale 1ns / 1ps

module tpu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpu_pkg::dp_status_t status_i,
  output tpu_pkg::ctl_cmd_t   cmd_o
);

  tpu_pkg::tpu_state_e                  state_q, state_d;
  logic [tpu_pkg::STEP_CNT_W-1:0]       cnt_q, cnt_d;
  logic                                 ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpu_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    ready   = 1'b0;
    unique case (state_q)
      tpu_pkg::ST_IDLE: begin
        ready        = !status_i.queue_full;
        cmd_o.accept = in_valid_i && ready;
        if (cmd_o.accept && status_i.need_divide) begin
          state_d = tpu_pkg::ST_DIVIDE;
          cnt_d   = '0;
        end
      end
      tpu_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == tpu_pkg::STEP_CNT_W'(tpu_pkg::DIV_STEPS - 1)) begin
          state_d = tpu_pkg::ST_WRAP;
        end
      end
      tpu_pkg::ST_WRAP: begin
        cmd_o.div_finish = 1'b1;
        state_d          = tpu_pkg::ST_IDLE;
      end
      default: state_d = tpu_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o = ready;

endmodule

@@ src/tpu_datapath.sv @@
// Datapath of the pattern unpacker: config registers, parse state, cell build, divider, result buffer.
// Depends on tpu_pkg; driven by tpu_ctrl commands.
`timescale 1ns / 1ps

module tpu_datapath #(
  parameter int unsigned MAX_ROWS     = 256,
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tpu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tpu_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [tpu_pkg::DATA_W-1:0]         in_byte_i,
  input  logic                               in_last_i,
  input  tpu_pkg::ctl_cmd_t                  cmd_i,
  output tpu_pkg::dp_status_t                status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tpu_pkg::cell_t                     out_cell_o
);

  localparam int unsigned DW = tpu_pkg::DATA_W;

  function automatic logic [DW-1:0] note_map(input logic [DW-1:0] n);
    logic [DW-1:0] r;
    if (n == '0) r = '0;
    else if (n > tpu_pkg::NOTE_LAST) r = tpu_pkg::NOTE_OFF;
    else r = n + tpu_pkg::NOTE_SHIFT;
    return r;
  endfunction

  // Configuration
  logic                                packed_mode_q;
  logic [tpu_pkg::ROWCFG_W-1:0]        row_count_q;
  logic [tpu_pkg::CHCFG_W-1:0]         chan_count_q;
  logic [tpu_pkg::ROWCFG_W-1:0]        rows_eff;
  logic [tpu_pkg::CHCFG_W-1:0]         chans_eff;

  // Pattern state
  logic [tpu_pkg::PHASE_W-1:0]         phase_q, phase_d;
  logic [6:0]                          mask_q, mask_d;
  logic [DW-1:0]                       repeat_q, repeat_d;
  logic [DW-1:0]                       fb_q [tpu_pkg::NFIELDS];
  logic [DW-1:0]                       fb_d [tpu_pkg::NFIELDS];
  logic [tpu_pkg::ROW_W-1:0]           row_q, row_d;
  logic [tpu_pkg::CH_W-1:0]            chan_q, chan_d;
  logic [tpu_pkg::REC_W-1:0]           rec_q, rec_d;
  logic                                fin_q, fin_d;
  logic [tpu_pkg::DIV_W-1:0]           rem_q, rem_d;
  logic [tpu_pkg::DIV_W-1:0]           dq_q, dq_d;

  // Step signals
  logic                                emit, advance, take_mask, need_div;
  logic [DW-1:0]                       adv_repeat;
  logic [tpu_pkg::PHASE_W-1:0]         pos;
  logic [6:0]                          low_bit, mask_rest;
  logic [tpu_pkg::IDX_W-1:0]           emit_idx;
  logic [tpu_pkg::REC_W-1:0]           idx_full, cell_limit;
  logic [tpu_pkg::DIV_W-1:0]           total, q_fast, r_fast, shifted;
  logic [tpu_pkg::DIV_W:0]             diff1, diff2;
  logic [tpu_pkg::DIV_W:0]             ch_sum;
  logic [DW-1:0]                       vol;
  tpu_pkg::cell_t                      new_cell;

  // Result buffer: output register plus one skid entry
  tpu_pkg::cell_t                      out_q, skid_q;
  logic                                out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic                                pop, load_out, load_skid;

  assign rows_eff  = (row_count_q == '0) ? tpu_pkg::ROWCFG_W'(1) :
                     (row_count_q > tpu_pkg::ROWCFG_W'(MAX_ROWS)) ?
                     tpu_pkg::ROWCFG_W'(MAX_ROWS) : row_count_q;
  assign chans_eff = (chan_count_q < tpu_pkg::MIN_CHANNELS) ? tpu_pkg::MIN_CHANNELS :
                     (chan_count_q > tpu_pkg::CHCFG_W'(MAX_CHANNELS)) ?
                     tpu_pkg::CHCFG_W'(MAX_CHANNELS) : chan_count_q;

  assign idx_full   = tpu_pkg::REC_W'(row_q) * tpu_pkg::REC_W'(chans_eff)
                    + tpu_pkg::REC_W'(chan_q);
  assign cell_limit = tpu_pkg::REC_W'(rows_eff) * tpu_pkg::REC_W'(chans_eff);

  assign low_bit   = mask_q & (~mask_q + 7'd1);
  assign mask_rest = mask_q & (mask_q - 7'd1);
  assign pos       = (phase_q > tpu_pkg::PH_POS_LAST) ? tpu_pkg::PH_MASK : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packed_mode_q <= tpu_pkg::RST_PACKED_MODE;
      row_count_q   <= tpu_pkg::RST_ROW_COUNT;
      chan_count_q  <= tpu_pkg::RST_CHAN_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpu_pkg::CFG_PACKED_MODE:   packed_mode_q <= cfg_data_i[0];
        tpu_pkg::CFG_ROW_COUNT:     row_count_q   <= cfg_data_i;
        tpu_pkg::CFG_CHANNEL_COUNT: chan_count_q  <= cfg_data_i[tpu_pkg::CHCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    mask_d     = mask_q;
    repeat_d   = repeat_q;
    fb_d       = fb_q;
    row_d      = row_q;
    chan_d     = chan_q;
    rec_d      = rec_q;
    fin_d      = fin_q;
    rem_d      = rem_q;
    dq_d       = dq_q;
    emit       = 1'b0;
    emit_idx   = idx_full[tpu_pkg::IDX_W-1:0];
    advance    = 1'b0;
    take_mask  = 1'b0;
    need_div   = 1'b0;
    adv_repeat = repeat_q;
    total      = '0;
    diff1      = '0;
    diff2      = '0;
    q_fast     = '0;
    r_fast     = '0;
    ch_sum     = '0;
    shifted    = '0;

    if (cmd_i.accept && !fin_q) begin
      if (packed_mode_q) begin
        if (phase_q == tpu_pkg::PH_REPEAT) begin
          repeat_d = in_byte_i;
          phase_d  = tpu_pkg::PH_MASK_FF;
        end else if (phase_q == tpu_pkg::PH_MASK_FF) begin
          take_mask = 1'b1;
        end else if (phase_q >= tpu_pkg::PH_FIELDS && mask_q != '0) begin
          for (int k = 0; k < tpu_pkg::NFIELDS; k++) begin
            if (low_bit[k]) fb_d[k] = in_byte_i;
          end
          mask_d = mask_rest;
          if (mask_rest == '0) begin
            emit    = 1'b1;
            advance = 1'b1;
          end
        end else if (in_byte_i == tpu_pkg::REPEAT_MARK) begin
          repeat_d = '0;
          phase_d  = tpu_pkg::PH_REPEAT;
        end else begin
          repeat_d   = '0;
          adv_repeat = '0;
          take_mask  = 1'b1;
        end

        if (take_mask) begin
          fb_d   = '{default: '0};
          mask_d = in_byte_i[6:0] & tpu_pkg::MASK_BITS[6:0];
          if ((in_byte_i & tpu_pkg::MASK_BITS) != '0) phase_d = tpu_pkg::PH_FIELDS;
          else advance = 1'b1;
        end
      end else begin
        fb_d[pos] = in_byte_i;
        if (pos < tpu_pkg::PH_POS_LAST) begin
          phase_d = pos + 1'b1;
        end else begin
          phase_d = tpu_pkg::PH_MASK;
          if (!in_last_i) begin
            emit     = 1'b1;
            emit_idx = rec_q[tpu_pkg::IDX_W-1:0];
            rec_d    = rec_q + 1'b1;
            if (rec_d >= cell_limit) fin_d = 1'b1;
          end
        end
      end

      // Advance by repeat + 1; totals below two row lengths resolve here, the rest go to the divider
      if (advance) begin
        repeat_d = '0;
        phase_d  = tpu_pkg::PH_MASK;
        mask_d   = '0;
        total    = tpu_pkg::DIV_W'(row_q) + tpu_pkg::DIV_W'(adv_repeat) + 1'b1;
        diff1    = {1'b0, total} - {1'b0, rows_eff};
        diff2    = diff1 - {1'b0, rows_eff};
        if (diff1[tpu_pkg::DIV_W]) begin
          q_fast = '0;
          r_fast = total;
        end else begin
          q_fast = tpu_pkg::DIV_W'(1);
          r_fast = diff1[tpu_pkg::DIV_W-1:0];
        end
        if (!diff1[tpu_pkg::DIV_W] && !diff2[tpu_pkg::DIV_W]) begin
          need_div = 1'b1;
          dq_d     = total;
          rem_d    = '0;
        end else begin
          ch_sum = (tpu_pkg::DIV_W + 1)'(chan_q) + (tpu_pkg::DIV_W + 1)'(q_fast);
          row_d  = r_fast[tpu_pkg::ROW_W-1:0];
          if (ch_sum >= (tpu_pkg::DIV_W + 1)'(chans_eff)) begin
            fin_d  = 1'b1;
            chan_d = '0;
          end else begin
            chan_d = ch_sum[tpu_pkg::CH_W-1:0];
          end
        end
      end
    end

    // Restoring divide, one quotient bit per step
    if (cmd_i.div_step) begin
      shifted = {rem_q[tpu_pkg::DIV_W-2:0], dq_q[tpu_pkg::DIV_W-1]};
      if (shifted >= rows_eff) begin
        rem_d = shifted - rows_eff;
        dq_d  = {dq_q[tpu_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        dq_d  = {dq_q[tpu_pkg::DIV_W-2:0], 1'b0};
      end
    end

    if (cmd_i.div_finish) begin
      ch_sum = (tpu_pkg::DIV_W + 1)'(chan_q) + (tpu_pkg::DIV_W + 1)'(dq_q);
      row_d  = rem_q[tpu_pkg::ROW_W-1:0];
      if (ch_sum >= (tpu_pkg::DIV_W + 1)'(chans_eff)) begin
        fin_d  = 1'b1;
        chan_d = '0;
      end else begin
        chan_d = ch_sum[tpu_pkg::CH_W-1:0];
      end
    end

    // Build the result from the field bytes as this transaction leaves them
    vol                     = fb_d[tpu_pkg::F_VOL];
    new_cell.cell_index     = emit_idx;
    new_cell.note_code      = note_map(fb_d[tpu_pkg::F_NOTE]);
    new_cell.instrument     = fb_d[tpu_pkg::F_INSTR];
    new_cell.effect_code    = fb_d[tpu_pkg::F_EFFECT];
    new_cell.effect_arg_one = fb_d[tpu_pkg::F_ARG1];
    new_cell.effect_arg_two = fb_d[tpu_pkg::F_ARG2];
    if (vol >= tpu_pkg::VOL_SET_LO && vol <= tpu_pkg::VOL_SET_HI) begin
      new_cell.volume_kind  = tpu_pkg::VK_SET;
      new_cell.volume_value = 7'((vol - tpu_pkg::VOL_SET_LO) >> 1);
    end else if (vol >= tpu_pkg::VOL_SLD_LO && vol <= tpu_pkg::VOL_SLD_HI) begin
      new_cell.volume_kind  = tpu_pkg::VK_SLIDE_DN + 3'(vol[7:4] - tpu_pkg::VOL_SLD_NIB);
      new_cell.volume_value = {3'b000, vol[3:0]};
    end else begin
      new_cell.volume_kind  = tpu_pkg::VK_NONE;
      new_cell.volume_value = '0;
    end

    // End of pattern data: drop any partial cell and return to the start
    if (cmd_i.accept && in_last_i) begin
      phase_d  = tpu_pkg::PH_MASK;
      mask_d   = '0;
      repeat_d = '0;
      fb_d     = '{default: '0};
      row_d    = '0;
      chan_d   = '0;
      rec_d    = '0;
      fin_d    = 1'b0;
      need_div = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tpu_pkg::PH_MASK;
      mask_q   <= '0;
      repeat_q <= '0;
      fb_q     <= '{default: '0};
      row_q    <= '0;
      chan_q   <= '0;
      rec_q    <= '0;
      fin_q    <= 1'b0;
      rem_q    <= '0;
      dq_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      mask_q   <= mask_d;
      repeat_q <= repeat_d;
      fb_q     <= fb_d;
      row_q    <= row_d;
      chan_q   <= chan_d;
      rec_q    <= rec_d;
      fin_q    <= fin_d;
      rem_q    <= rem_d;
      dq_q     <= dq_d;
    end
  end

  // Result buffer; the skid entry fills only while the output register stalls
  assign pop = out_vld_q && out_ready_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        load_out   = 1'b1;
        out_vld_d  = 1'b1;
        skid_vld_d = emit;
        load_skid  = emit;
      end else begin
        load_out  = emit;
        out_vld_d = emit;
      end
    end else if (emit) begin
      skid_vld_d = 1'b1;
      load_skid  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= skid_vld_q ? skid_q : new_cell;
    if (load_skid) skid_q <= new_cell;
  end

  assign status_o.need_divide = need_div;
  assign status_o.queue_full  = skid_vld_q;
  assign out_valid_o          = out_vld_q;
  assign out_cell_o           = out_q;

endmodule

@@ src/tracker_pattern_unpacker.sv @@
// Top level of the pattern unpacker: stream ports, config write port, sequencer and datapath.
// Depends on tpu_pkg, tpu_ctrl and tpu_datapath.
`timescale 1ns / 1ps

// Pattern data unpacker.
// Input stream: one byte of pattern data per transaction on s_axis; s_axis_tlast marks the
// last byte of a pattern and returns all pattern state (row, channel, record count, partial
// cell) to the start once that byte is handled.
// Output stream: one decoded cell per transaction on m_axis, in order of completion.
// Config port: write cfg_data_i to register cfg_idx_i when cfg_we_i is high; index 0 selects
// packed mode, 1 the row count, 2 the channel count. Write only while the block is idle.
// Each completed cell is registered in the output register, or in the skid entry on a stall.
// Throughput: one byte per cycle while s_axis_tready is high. In packed mode a row advance
// that carries across two or more row lengths (large repeat counts) runs the 9-step restoring
// divider and then a wrap state; s_axis_tready is low meanwhile.
// Reset: packed mode, 64 rows, 4 channels, pattern state cleared; no result pending.
// Stall: results sit in a two-entry buffer (output register plus skid entry); input keeps
// flowing while one result waits and is held off once both entries are full.

module tracker_pattern_unpacker #(
  parameter int unsigned MAX_ROWS     = 256,
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Config write port
  input  logic                           cfg_we_i,
  input  logic [tpu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Pattern bytes in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tlast,  // final_byte
  // Decoded cells out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [13:0] cell_index, [21:14] note_code, [29:22] instrument, [32:30] volume_kind,
  // [39:33] volume_value, [47:40] effect_code, [55:48] effect_arg_one,
  // [63:56] effect_arg_two
  output logic [tpu_pkg::CELL_W-1:0]     m_axis_tdata
);

  tpu_pkg::ctl_cmd_t   cmd;
  tpu_pkg::dp_status_t status;
  tpu_pkg::cell_t      out_cell;

  // Sequencer: hold input off while dividing or when the result buffer is full
  tpu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: parse, advance position, build the cell, buffer results
  tpu_datapath #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_cell_o  (out_cell)
  );

  assign m_axis_tdata = out_cell;

endmodule

@@ src/tpu_checker.sv @@
// Port-level checker for the pattern unpacker, bound to the top level.
// Depends on tpu_pkg and tracker_pattern_unpacker_assert.svh.
`timescale 1ns / 1ps
`include "tracker_pattern_unpacker_assert.svh"

module tpu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tpu_pkg::CELL_W-1:0]     m_axis_tdata
);

  tpu_pkg::cell_t              obs;
  logic [tpu_pkg::CELL_W:0]    out_bus;
  logic                        in_xfer, out_stall, note_ok, vol_ok;

  assign obs       = tpu_pkg::cell_t'(m_axis_tdata);
  assign out_bus   = {m_axis_tvalid, m_axis_tdata};
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Note remap yields none, note off, or a shifted note
  assign note_ok = (obs.note_code == '0) || (obs.note_code == tpu_pkg::NOTE_OFF) ||
                   (obs.note_code > tpu_pkg::NOTE_SHIFT &&
                    obs.note_code <= tpu_pkg::NOTE_LAST + tpu_pkg::NOTE_SHIFT);

  // Volume split stays within its kinds and levels
  assign vol_ok = (obs.volume_kind <= tpu_pkg::VK_FINE_UP) && (obs.volume_value <= 7'd64) &&
                  (obs.volume_kind != tpu_pkg::VK_NONE || obs.volume_value == '0);

  // A stalled result holds
  `TPU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, $stable(out_bus), "stalled result moved")

  // A result only appears right after an input transaction
  `TPU_ASSERT_IMPL(a_out_cause, clk_i, rst_ni, $rose(m_axis_tvalid), $past(in_xfer), "orphan result")

  `TPU_ASSERT_IMPL(a_note_range, clk_i, rst_ni, m_axis_tvalid, note_ok, "note code out of range")

  `TPU_ASSERT_IMPL(a_vol_range, clk_i, rst_ni, m_axis_tvalid, vol_ok, "volume split out of range")

endmodule

bind tracker_pattern_unpacker tpu_checker u_tpu_checker (.*);
